// File: rtl/lcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcv_pkg;

  localparam int CODE_W     = 8;
  localparam int POS_W      = 6;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int GROUPS     = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID   = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_INVALID = 3'd2,
    ST_ORDER   = 3'd3,
    ST_CODE    = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALID_CODE   = 3'd0,
    REG_SIDE         = 3'd1,
    REG_VERTICAL     = 3'd2,
    REG_TRANSVERSE   = 3'd3,
    REG_LONGITUDINAL = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] valid_code;
    logic [CFG_DATA_W-1:0] side;
    logic [CFG_DATA_W-1:0] vertical;
    logic [CFG_DATA_W-1:0] transverse;
    logic [CFG_DATA_W-1:0] longitudinal;
  } lcv_cfg_t;

  typedef struct packed {
    logic             done;
    status_t          status;
    logic [POS_W-1:0] position;
  } lcv_res_t;

endpackage

`default_nettype wire

// File: rtl/lcv_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       empty_string;

  modport source (output valid, output char_code, output last_char, output empty_string,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input empty_string,
                output ready);
endinterface

interface lcv_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] error_position;

  modport source (output valid, output status, output error_position, input ready);
  modport sink (input valid, input status, input error_position, output ready);
endinterface

`default_nettype wire

// File: rtl/lcv_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module lcv_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lcv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcv_pkg::CFG_DATA_W-1:0] cfg_data,
  output lcv_pkg::lcv_cfg_t                   cfg
);
  import lcv_pkg::*;

  lcv_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VALID_CODE: begin
          regs.valid_code <= cfg_data;
        end
        REG_SIDE: begin
          regs.side <= cfg_data;
        end
        REG_VERTICAL: begin
          regs.vertical <= cfg_data;
        end
        REG_TRANSVERSE: begin
          regs.transverse <= cfg_data;
        end
        REG_LONGITUDINAL: begin
          regs.longitudinal <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// File: rtl/lcv_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module lcv_scan #(
  parameter int MAX_LENGTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [lcv_pkg::CODE_W-1:0] char_code,
  input  wire logic                       last_char,
  input  wire logic                       empty_string,
  input  wire lcv_pkg::lcv_cfg_t          cfg,
  output lcv_pkg::lcv_res_t               res
);
  import lcv_pkg::*;

  localparam int IDX_W = $clog2(MAX_LENGTH);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LENGTH - 1);

  logic [IDX_W-1:0]  char_index, char_index_next;
  logic              digits_seen, digits_seen_next;
  logic              previous_was_digit, previous_was_digit_next;
  logic              letters_seen, letters_seen_next;
  logic [GROUPS-1:0] groups_used, groups_used_next;
  logic [CODE_W-1:0] previous_char, previous_char_next;
  logic              all_whitespace, all_whitespace_next;
  status_t           error_code, error_code_next;
  logic [IDX_W-1:0]  error_index, error_index_next;

  logic              is_digit;
  logic              is_space;
  logic              in_range;
  logic [5:0]        bit_sel;
  logic [GROUPS-1:0] group_bit;

  always_comb begin
    is_digit  = char_code inside {[8'h30:8'h39]};
    is_space  = char_code inside {8'h20, [8'h09:8'h0D]};
    in_range  = (char_code[7:6] == 2'b01);
    bit_sel   = char_code[5:0];
    group_bit = '0;
    if (cfg.side[bit_sel]) begin
      group_bit = 4'b0001;
    end else if (cfg.vertical[bit_sel]) begin
      group_bit = 4'b0010;
    end else if (cfg.transverse[bit_sel]) begin
      group_bit = 4'b0100;
    end else if (cfg.longitudinal[bit_sel]) begin
      group_bit = 4'b1000;
    end
  end

  always_comb begin
    char_index_next         = (char_index < IDX_MAX) ? char_index + 1'b1 : char_index;
    digits_seen_next        = digits_seen;
    previous_was_digit_next = previous_was_digit;
    letters_seen_next       = letters_seen;
    groups_used_next        = groups_used;
    previous_char_next      = previous_char;
    all_whitespace_next     = all_whitespace & is_space;
    error_code_next         = error_code;
    error_index_next        = error_index;

    if (error_code == ST_VALID) begin
      if (is_digit) begin
        if (digits_seen && !previous_was_digit) begin
          error_code_next  = ST_INVALID;
          error_index_next = char_index;
        end else if (letters_seen) begin
          error_code_next  = ST_ORDER;
          error_index_next = char_index;
        end else begin
          digits_seen_next        = 1'b1;
          previous_was_digit_next = 1'b1;
          previous_char_next      = char_code;
        end
      end else begin
        letters_seen_next = 1'b1;
        if (!(in_range && cfg.valid_code[bit_sel])) begin
          error_code_next  = ST_CODE;
          error_index_next = char_index;
        end else if ((groups_used & group_bit) != '0) begin
          error_code_next  = ST_INVALID;
          error_index_next = char_index;
        end else begin
          groups_used_next = groups_used | group_bit;
          if (letters_seen && !previous_was_digit && (char_code < previous_char)) begin
            error_code_next  = ST_ORDER;
            error_index_next = char_index;
          end else begin
            previous_was_digit_next = 1'b0;
            previous_char_next      = char_code;
          end
        end
      end
    end
  end

  always_comb begin
    res.done     = last_char | empty_string;
    res.status   = ST_VALID;
    res.position = '0;
    if (empty_string || all_whitespace_next) begin
      res.status = ST_EMPTY;
    end else if (error_code_next != ST_VALID) begin
      res.status   = error_code_next;
      res.position = POS_W'(error_index_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && res.done)) begin
      char_index         <= '0;
      digits_seen        <= 1'b0;
      previous_was_digit <= 1'b0;
      letters_seen       <= 1'b0;
      groups_used        <= '0;
      previous_char      <= '0;
      all_whitespace     <= 1'b1;
      error_code         <= ST_VALID;
      error_index        <= '0;
    end else if (step) begin
      char_index         <= char_index_next;
      digits_seen        <= digits_seen_next;
      previous_was_digit <= previous_was_digit_next;
      letters_seen       <= letters_seen_next;
      groups_used        <= groups_used_next;
      previous_char      <= previous_char_next;
      all_whitespace     <= all_whitespace_next;
      error_code         <= error_code_next;
      error_index        <= error_index_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_VALID) && !(step && res.done) |=>
      (error_code == $past(error_code)) && (error_index == $past(error_index)))
    else $error("recorded error changed before the string ended");

  a_index_count: assert property (@(posedge clk) disable iff (rst)
    step && !res.done && (char_index < IDX_MAX) |=> char_index == $past(char_index) + 1'b1)
    else $error("character index did not advance");

  a_error_in_string: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_VALID) |-> (error_index < char_index) || (char_index == IDX_MAX))
    else $error("error recorded beyond the current character");
`endif

endmodule

`default_nettype wire

// File: rtl/location_code_validator_core.sv
// Location code validator. Characters of a location string arrive on the chars channel one
// request per cycle; the block sustains one character per clock with no gaps while results
// are taken. Each string ends with a character marked last_char, or with an empty_string
// request, and yields one request on the result channel: the character passes the input
// register and the character check, then the result register. The check is a single step
// of flag logic against the five 64-bit mask registers. Mask registers are written through
// cfg_we, cfg_index and cfg_data; the user must do so only while no string is in flight, as
// the block does not enforce it. Character positions count up to MAX_LENGTH-1, then hold.
`timescale 1ns / 1ps
`default_nettype none

module location_code_validator_core #(
  parameter int MAX_LENGTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lcv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcv_pkg::CFG_DATA_W-1:0] cfg_data,
  lcv_char_if.sink                            chars,
  lcv_result_if.source                        result
);
  import lcv_pkg::*;

  lcv_cfg_t cfg;
  lcv_res_t res;

  logic              s1_valid;
  logic [CODE_W-1:0] s1_char_code;
  logic              s1_last_char;
  logic              s1_empty_string;
  logic              s1_advance;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_position;

  lcv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcv_scan #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_advance),
    .char_code    (s1_char_code),
    .last_char    (s1_last_char),
    .empty_string (s1_empty_string),
    .cfg          (cfg),
    .res          (res)
  );

  assign s1_advance  = s1_valid && (!res.done || !out_valid || result.ready);
  assign chars.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char_code    <= chars.char_code;
      s1_last_char    <= chars.last_char;
      s1_empty_string <= chars.empty_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && res.done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && res.done) begin
      out_status   <= res.status;
      out_position <= res.position;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.error_position = out_position;

`ifndef NO_ASSERTIONS
  a_clean_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_status == ST_VALID) || (out_status == ST_EMPTY)) |->
      out_position == '0)
    else $error("position reported without an error");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> s1_valid && res.done && out_valid && !result.ready)
    else $error("input stalled without a pending result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid) && $past(res.done))
    else $error("result appeared without a finished string");
`endif

endmodule

`default_nettype wire
